// ===== design/brl_pkg.sv =====
package brl_pkg;

  localparam int MAX_DIM   = 64;
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int ADDR_W    = 12;
  localparam int COLOR_W   = 16;
  localparam int ERR_W     = COORD_W + 4;
  localparam int FRAME_MAX = 64;
  localparam int Q_PTR_W   = 1;
  localparam int Q_DEPTH   = 2;
  localparam int Q_CNT_W   = 2;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [COLOR_W-1:0] color_t;

  // classified line request
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t xe;
    coord_t ye;
    coord_t adx;
    coord_t ady;
    logic   sx_neg;
    logic   sy_neg;
    color_t color;
  } cmd_t;

  typedef struct packed {
    dim_t width;
    dim_t height;
  } cfg_t;

  function automatic coord_t clamp_coord(coord_t v);
    return (v > coord_t'(MAX_DIM - 1)) ? coord_t'(MAX_DIM - 1) : v;
  endfunction

  function automatic dim_t sat_dim(dim_t v);
    return (v > dim_t'(FRAME_MAX)) ? dim_t'(FRAME_MAX) : v;
  endfunction

endpackage

// ===== design/brl_cmd_if.sv =====
interface brl_cmd_if;
  import brl_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t draw_color;

  modport source (output valid, start_x, start_y, end_x, end_y, draw_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, draw_color, output ready);
endinterface

// ===== design/brl_pix_if.sv =====
interface brl_pix_if;
  import brl_pkg::*;

  logic                valid;
  logic                ready;
  coord_t              pix_x;
  coord_t              pix_y;
  logic [ADDR_W-1:0]   pixel_addr;
  color_t              pix_color;
  logic                visible;
  logic                last_pixel;

  modport source (output valid, pix_x, pix_y, pixel_addr, pix_color, visible, last_pixel,
                  input ready);
  modport sink   (input valid, pix_x, pix_y, pixel_addr, pix_color, visible, last_pixel,
                  output ready);
endinterface

// ===== design/brl_front.sv =====
module brl_front (
  brl_cmd_if.sink       cmd,
  output brl_pkg::cmd_t push_data,
  output logic          push_valid,
  input  logic          push_ready
);
  import brl_pkg::*;

  coord_t x0, y0, x1, y1;

  assign x0 = clamp_coord(cmd.start_x);
  assign y0 = clamp_coord(cmd.start_y);
  assign x1 = clamp_coord(cmd.end_x);
  assign y1 = clamp_coord(cmd.end_y);

  always_comb begin
    push_data.x      = x0;
    push_data.y      = y0;
    push_data.xe     = x1;
    push_data.ye     = y1;
    push_data.adx    = (x1 >= x0) ? coord_t'(x1 - x0) : coord_t'(x0 - x1);
    push_data.ady    = (y1 >= y0) ? coord_t'(y1 - y0) : coord_t'(y0 - y1);
    push_data.sx_neg = !(x0 < x1);
    push_data.sy_neg = !(y0 < y1);
    push_data.color  = cmd.draw_color;
  end

  assign push_valid = cmd.valid;
  assign cmd.ready  = push_ready;

endmodule

// ===== design/brl_queue.sv =====
module brl_queue (
  input  logic          clk,
  input  logic          rst,
  input  brl_pkg::cmd_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output brl_pkg::cmd_t pop_data,
  output logic          pop_valid,
  input  logic          pop
);
  import brl_pkg::*;

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/brl_walk.sv =====
module brl_walk (
  input  logic          clk,
  input  logic          rst,
  input  brl_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_pop,
  input  brl_pkg::cfg_t cfg,
  brl_pix_if.source     pix
);
  import brl_pkg::*;

  localparam int PROD_W = COORD_W + DIM_W;

  logic                    active;
  cmd_t                    cur;
  coord_t                  x;
  coord_t                  y;
  logic signed [ERR_W-1:0] err;

  logic                    out_valid;
  coord_t                  out_x;
  coord_t                  out_y;
  logic [ADDR_W-1:0]       out_addr;
  color_t                  out_color;
  logic                    out_visible;
  logic                    out_last;

  logic                    emit;
  logic                    is_last;
  logic                    load_cmd;
  logic signed [ERR_W-1:0] dx_s;
  logic signed [ERR_W-1:0] dy_s;
  logic signed [ERR_W-1:0] e2;
  logic                    step_x;
  logic                    step_y;
  logic signed [ERR_W-1:0] err_next;
  logic [PROD_W-1:0]       addr_full;

  assign emit     = active && (!out_valid || pix.ready);
  assign is_last  = (x == cur.xe) && (y == cur.ye);
  assign load_cmd = q_valid && (!active || (emit && is_last));
  assign q_pop    = load_cmd;

  // error term: dx positive, dy negative
  assign dx_s   = $signed({{(ERR_W-COORD_W){1'b0}}, cur.adx});
  assign dy_s   = -$signed({{(ERR_W-COORD_W){1'b0}}, cur.ady});
  assign e2     = err <<< 1;
  assign step_x = (e2 >= dy_s);
  assign step_y = (e2 <= dx_s);

  always_comb begin
    err_next = err;
    if (step_x) err_next = err_next + dy_s;
    if (step_y) err_next = err_next + dx_s;
  end

  assign addr_full = PROD_W'(y) * PROD_W'(cfg.width) + PROD_W'(x);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load_cmd) begin
      active <= 1'b1;
    end else if (emit && is_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      cur <= q_data;
      x   <= q_data.x;
      y   <= q_data.y;
      err <= $signed({{(ERR_W-COORD_W){1'b0}}, q_data.adx})
           - $signed({{(ERR_W-COORD_W){1'b0}}, q_data.ady});
    end else if (emit && !is_last) begin
      err <= err_next;
      if (step_x) x <= cur.sx_neg ? coord_t'(x - 1'b1) : coord_t'(x + 1'b1);
      if (step_y) y <= cur.sy_neg ? coord_t'(y - 1'b1) : coord_t'(y + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x       <= x;
      out_y       <= y;
      out_addr    <= addr_full[ADDR_W-1:0];
      out_color   <= cur.color;
      out_visible <= ({1'b0, x} < cfg.width) && ({1'b0, y} < cfg.height);
      out_last    <= is_last;
    end
  end

  assign pix.valid      = out_valid;
  assign pix.pix_x      = out_x;
  assign pix.pix_y      = out_y;
  assign pix.pixel_addr = out_addr;
  assign pix.pix_color  = out_color;
  assign pix.visible    = out_visible;
  assign pix.last_pixel = out_last;

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    emit && is_last && !load_cmd |=> !active)
    else $error("walker still busy after last pixel");

  a_stall_holds_walk: assert property (@(posedge clk) disable iff (rst)
    active && !emit |=> $stable(x) && $stable(y) && $stable(err))
    else $error("walker moved while output stalled");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted pixel lost");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load_cmd |=> active)
    else $error("request taken but walker idle");

endmodule

// ===== design/bresenham_line_rasterizer.sv =====
// Line rasteriser: each request (two endpoints and a colour) yields
// max(|dx|,|dy|)+1 pixel results, from 1 to 64, one per clock while the
// pixel sink keeps up; the single error-term step of the walker sets that
// rate, and the next queued request starts on the cycle after its last
// pixel. A two-entry queue lets requests be taken while a line is drawn.
// Pixels outside frame_width x frame_height come out with visible low.
module bresenham_line_rasterizer (
  input  logic                             clk,
  input  logic                             rst,
  brl_cmd_if.sink                          cmd,
  brl_pix_if.source                        pix,
  input  logic                             write_en,
  input  logic [brl_pkg::REG_IDX_W-1:0]    reg_index,
  input  logic [brl_pkg::DIM_W-1:0]        write_data
);
  import brl_pkg::*;

  dim_t frame_width;
  dim_t frame_height;
  cfg_t cfg;
  cmd_t push_data;
  logic push_valid;
  logic push_ready;
  cmd_t q_data;
  logic q_valid;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= dim_t'(FRAME_MAX);
      frame_height <= dim_t'(FRAME_MAX);
    end else if (write_en) begin
      case (reg_index)
        REG_FRAME_WIDTH:  frame_width  <= write_data;
        REG_FRAME_HEIGHT: frame_height <= write_data;
        default: ;
      endcase
    end
  end

  assign cfg.width  = sat_dim(frame_width);
  assign cfg.height = sat_dim(frame_height);

  brl_front u_front (
    .cmd        (cmd),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  brl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (q_data),
    .pop_valid  (q_valid),
    .pop        (q_pop)
  );

  brl_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .pix     (pix)
  );

endmodule

// ===== dv/bresenham_line_rasterizer_test.sv =====
module bresenham_line_rasterizer_test;
  import brl_pkg::*;

  typedef struct packed {
    coord_t            x;
    coord_t            y;
    logic [ADDR_W-1:0] addr;
    color_t            color;
    logic              vis;
    logic              last;
  } pixel_t;

  typedef struct packed {
    dim_t   w;
    dim_t   h;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    color_t color;
    bit     typed;
    pixel_t px;
  } line_row_t;

  localparam int NUM_ROWS   = 22;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_REQS = 62;

  logic                 clk;
  logic                 rst;
  logic                 write_en;
  logic [REG_IDX_W-1:0] reg_index;
  logic [DIM_W-1:0]     write_data;

  brl_cmd_if cmd_ch ();
  brl_pix_if pix_ch ();

  bresenham_line_rasterizer u_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .pix        (pix_ch),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data)
  );

  dim_t   frame_w = 7'd64;
  dim_t   frame_h = 7'd64;
  bit     steady = 1'b0;
  int     pixel_errors = 0;
  pixel_t pending_pixels [$];

  // endpoints at extremes, several octants, clipping and saturated frames
  line_row_t line_rows [NUM_ROWS] = '{
    '{7'd64, 7'd64, 6'd0, 6'd0, 6'd0, 6'd0, 16'h0000, 1'b1,
      '{6'd0, 6'd0, 12'd0, 16'h0000, 1'b1, 1'b1}},
    '{7'd64, 7'd64, 6'd63, 6'd63, 6'd63, 6'd63, 16'hFFFF, 1'b1,
      '{6'd63, 6'd63, 12'd4095, 16'hFFFF, 1'b1, 1'b1}},
    '{7'd64, 7'd64, 6'd0, 6'd0, 6'd63, 6'd0, 16'hA5A5, 1'b0, '0},
    '{7'd64, 7'd64, 6'd63, 6'd0, 6'd0, 6'd0, 16'h5A5A, 1'b0, '0},
    '{7'd64, 7'd64, 6'd0, 6'd0, 6'd0, 6'd63, 16'h1234, 1'b0, '0},
    '{7'd64, 7'd64, 6'd0, 6'd63, 6'd0, 6'd0, 16'h8001, 1'b0, '0},
    '{7'd64, 7'd64, 6'd0, 6'd0, 6'd63, 6'd63, 16'hFFFF, 1'b0, '0},
    '{7'd64, 7'd64, 6'd63, 6'd0, 6'd0, 6'd63, 16'h0000, 1'b0, '0},
    '{7'd64, 7'd64, 6'd63, 6'd63, 6'd0, 6'd0, 16'h7FFF, 1'b0, '0},
    '{7'd64, 7'd64, 6'd10, 6'd5, 6'd13, 6'd40, 16'h0F0F, 1'b0, '0},
    '{7'd64, 7'd64, 6'd40, 6'd20, 6'd2, 6'd25, 16'hF0F0, 1'b0, '0},
    '{7'd64, 7'd64, 6'd30, 6'd30, 6'd31, 6'd29, 16'h5555, 1'b0, '0},
    '{7'd1, 7'd1, 6'd0, 6'd0, 6'd0, 6'd0, 16'hC3C3, 1'b1,
      '{6'd0, 6'd0, 12'd0, 16'hC3C3, 1'b1, 1'b1}},
    '{7'd1, 7'd1, 6'd1, 6'd0, 6'd1, 6'd0, 16'h3C3C, 1'b1,
      '{6'd1, 6'd0, 12'd1, 16'h3C3C, 1'b0, 1'b1}},
    '{7'd1, 7'd1, 6'd0, 6'd0, 6'd5, 6'd3, 16'hAAAA, 1'b0, '0},
    '{7'd0, 7'd0, 6'd5, 6'd7, 6'd5, 6'd7, 16'h00FF, 1'b1,
      '{6'd5, 6'd7, 12'd5, 16'h00FF, 1'b0, 1'b1}},
    '{7'd0, 7'd0, 6'd0, 6'd0, 6'd20, 6'd9, 16'h8888, 1'b0, '0},
    '{7'd127, 7'd127, 6'd63, 6'd63, 6'd63, 6'd63, 16'hFF00, 1'b1,
      '{6'd63, 6'd63, 12'd4095, 16'hFF00, 1'b1, 1'b1}},
    '{7'd127, 7'd127, 6'd0, 6'd63, 6'd63, 6'd0, 16'h6666, 1'b0, '0},
    '{7'd65, 7'd64, 6'd63, 6'd10, 6'd63, 6'd10, 16'h4321, 1'b1,
      '{6'd63, 6'd10, 12'd703, 16'h4321, 1'b1, 1'b1}},
    '{7'd32, 7'd16, 6'd0, 6'd0, 6'd63, 6'd63, 16'h2468, 1'b0, '0},
    '{7'd32, 7'd16, 6'd31, 6'd15, 6'd32, 6'd16, 16'h1357, 1'b0, '0}
  };

  dim_t phase_w [NUM_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd20, 7'd0};
  dim_t phase_h [NUM_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd127, 7'd45, 7'd0};

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // walk the error term and queue one pixel per step
  function automatic void trace_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                     color_t c);
    int     x, y, dx, dy, sx, sy, err, e2, w, h, n;
    bit     done;
    pixel_t p;
    w = (frame_w > 7'd64) ? 64 : int'(frame_w);
    h = (frame_h > 7'd64) ? 64 : int'(frame_h);
    x = int'(x0);
    y = int'(y0);
    dx = (x1 >= x0) ? int'(x1) - x : x - int'(x1);
    dy = (y1 >= y0) ? y - int'(y1) : int'(y1) - y;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    n = 0;
    done = 1'b0;
    while (!done && n < MAX_DIM) begin
      p.x = coord_t'(x);
      p.y = coord_t'(y);
      p.addr = ADDR_W'(y * w + x);
      p.color = c;
      p.vis = (x < w) && (y < h);
      p.last = (x == int'(x1)) && (y == int'(y1));
      pending_pixels.push_back(p);
      n++;
      done = p.last;
      if (!done) begin
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          x += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          y += sy;
        end
      end
    end
  endfunction

  task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input color_t c);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 10) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.start_x    <= sx;
    cmd_ch.start_y    <= sy;
    cmd_ch.end_x      <= ex;
    cmd_ch.end_y      <= ey;
    cmd_ch.draw_color <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame(input dim_t w, input dim_t h);
    @(negedge clk);
    write_en   <= 1'b1;
    reg_index  <= REG_FRAME_WIDTH;
    write_data <= w;
    @(negedge clk);
    reg_index  <= REG_FRAME_HEIGHT;
    write_data <= h;
    @(negedge clk);
    write_en   <= 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  function automatic coord_t near_coord(coord_t base);
    int t;
    t = int'(base) + $urandom_range(0, 14) - 7;
    if (t < 0) t = 0;
    if (t > MAX_DIM - 1) t = MAX_DIM - 1;
    return coord_t'(t);
  endfunction

  always @(negedge clk) begin
    pix_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin : pixel_check
    pixel_t got, want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      got = '{pix_ch.pix_x, pix_ch.pix_y, pix_ch.pixel_addr, pix_ch.pix_color,
              pix_ch.visible, pix_ch.last_pixel};
      if (pending_pixels.size() == 0) begin
        pixel_errors++;
        if (pixel_errors <= 10)
          $display("unexpected pixel x=%0d y=%0d addr=%0d color=%h vis=%b last=%b",
                   got.x, got.y, got.addr, got.color, got.vis, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
            got.color !== want.color || got.vis !== want.vis || got.last !== want.last) begin
          pixel_errors++;
          if (pixel_errors <= 10) begin
            $write("pixel mismatch: exp x=%0d y=%0d addr=%0d color=%h vis=%b last=%b",
                   want.x, want.y, want.addr, want.color, want.vis, want.last);
            $display(" got x=%0d y=%0d addr=%0d color=%h vis=%b last=%b",
                     got.x, got.y, got.addr, got.color, got.vis, got.last);
          end
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    coord_t sx, sy, ex, ey;
    rst        = 1'b1;
    write_en   = 1'b0;
    reg_index  = REG_FRAME_WIDTH;
    write_data = '0;
    pix_ch.ready      = 1'b0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.start_x    = '0;
    cmd_ch.start_y    = '0;
    cmd_ch.end_x      = '0;
    cmd_ch.end_y      = '0;
    cmd_ch.draw_color = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first rows run on the reset frame size
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (line_rows[i].w != frame_w || line_rows[i].h != frame_h) begin
        drain();
        set_frame(line_rows[i].w, line_rows[i].h);
      end
      send_line(line_rows[i].sx, line_rows[i].sy, line_rows[i].ex, line_rows[i].ey,
                line_rows[i].color);
      if (line_rows[i].typed)
        pending_pixels.push_back(line_rows[i].px);
      else
        trace_line(line_rows[i].sx, line_rows[i].sy, line_rows[i].ex, line_rows[i].ey,
                   line_rows[i].color);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == NUM_PHASES - 1)
        set_frame(dim_t'($urandom_range(0, 127)), dim_t'($urandom_range(0, 127)));
      else
        set_frame(phase_w[ph], phase_h[ph]);
      steady = (ph == 3);
      for (int k = 0; k < PHASE_REQS; k++) begin
        sx = coord_t'($urandom_range(0, MAX_DIM - 1));
        sy = coord_t'($urandom_range(0, MAX_DIM - 1));
        if ($urandom_range(0, 99) < 65) begin
          ex = near_coord(sx);
          ey = near_coord(sy);
        end else begin
          ex = coord_t'($urandom_range(0, MAX_DIM - 1));
          ey = coord_t'($urandom_range(0, MAX_DIM - 1));
        end
        send_line(sx, sy, ex, ey, color_t'($urandom));
        trace_line(sx, sy, ex, ey, color_t'(cmd_ch.draw_color));
      end
    end
    steady = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      pixel_errors += pending_pixels.size();
      $display("%0d expected pixels never arrived", pending_pixels.size());
    end
    if (pixel_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== bresenham_line_rasterizer.f =====
design/brl_pkg.sv
design/brl_cmd_if.sv
design/brl_pix_if.sv
design/brl_front.sv
design/brl_queue.sv
design/brl_walk.sv
design/bresenham_line_rasterizer.sv
dv/bresenham_line_rasterizer_test.sv
